/* sv/rapa_pkg.sv */
// ---------------------------------------------------------------------------
// rapa_pkg
// Shared widths, codes and types of the region area and perimeter accumulator.
// ---------------------------------------------------------------------------
package rapa_pkg;

  // field widths of the channels and the configuration port
  localparam int OP_W       = 2;
  localparam int LABEL_W    = 12;
  localparam int AREA_W     = 21;
  localparam int PERIM_W    = 23;
  localparam int SIZE_W     = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  // per-update perimeter increment, at most four sides
  localparam int INC_W      = 3;

  // default sizes of the stores
  localparam int DEF_MAX_LABELS = 4096;
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  // register values after reset
  localparam logic [SIZE_W-1:0]  RST_IMAGE_WIDTH  = SIZE_W'(1024);
  localparam logic [SIZE_W-1:0]  RST_IMAGE_HEIGHT = SIZE_W'(1024);
  localparam logic [LABEL_W-1:0] RST_BACKGROUND   = '0;

  // saturation limits of the counts
  localparam logic [AREA_W-1:0]  AREA_MAX  = '1;
  localparam logic [PERIM_W-1:0] PERIM_MAX = '1;

  // item operations
  typedef enum logic [OP_W-1:0] {
    OP_PIXEL = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1,
    CFG_BACKGROUND   = 2'd2
  } cfg_idx_e;

  // where the current pixel sits relative to the image border
  typedef struct packed {
    logic x_first;
    logic x_last;
    logic y_first;
    logic y_last;
  } pos_flags_t;

endpackage

/* sv/rapa_if.sv */
// ---------------------------------------------------------------------------
// rapa_item_if / rapa_result_if
// Valid/ready channels carrying input items and read results.
// ---------------------------------------------------------------------------
interface rapa_item_if import rapa_pkg::*;;
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    op;
  logic [LABEL_W-1:0] label;

  modport source (output valid, output op, output label, input ready);
  modport sink   (input valid, input op, input label, output ready);
endinterface

interface rapa_result_if import rapa_pkg::*;;
  logic               valid;
  logic               ready;
  logic [AREA_W-1:0]  area;
  logic [PERIM_W-1:0] perimeter;

  modport source (output valid, output area, output perimeter, input ready);
  modport sink   (input valid, input area, input perimeter, output ready);
endinterface

/* sv/rapa_raster.sv */
// ---------------------------------------------------------------------------
// rapa_raster
// Raster position tracker: column and row of the next pixel with border flags.
// ---------------------------------------------------------------------------
module rapa_raster import rapa_pkg::*; #(
  parameter int  MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int  MAX_HEIGHT = DEF_MAX_HEIGHT,
  localparam int XW         = $clog2(MAX_WIDTH)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic              restart_i,
  input  logic [SIZE_W-1:0] image_width_i,
  input  logic [SIZE_W-1:0] image_height_i,
  output logic [XW-1:0]     x_o,
  output pos_flags_t        flags_o
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int HW = $clog2(MAX_HEIGHT + 1);

  logic [XW-1:0] col_q, col_d;
  logic [YW-1:0] row_q, row_d;
  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;
  logic          col_wrap;
  logic [HW-1:0] row_a;
  logic [XW-1:0] x;
  logic [YW-1:0] y;

  // image size clamped to the supported range
  always_comb begin
    if (image_width_i < SIZE_W'(2)) begin
      w_eff = WW'(2);
    end else if (32'(image_width_i) > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(image_width_i);
    end
    if (image_height_i < SIZE_W'(2)) begin
      h_eff = HW'(2);
    end else if (32'(image_height_i) > 32'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(image_height_i);
    end
  end

  // position of this pixel, with fix-up when the size shrank mid-frame
  always_comb begin
    col_wrap = WW'(col_q) >= w_eff;
    row_a    = col_wrap ? HW'(row_q) + HW'(1) : HW'(row_q);
    x        = col_wrap ? '0 : col_q;
    y        = (row_a >= h_eff) ? '0 : YW'(row_a);

    flags_o.x_first = (x == '0);
    flags_o.x_last  = (WW'(x) + WW'(1) == w_eff);
    flags_o.y_first = (y == '0);
    flags_o.y_last  = (HW'(y) + HW'(1) == h_eff);
  end

  assign x_o = x;

  // advance to the next pixel, wrapping at row and frame ends
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (restart_i) begin
      col_d = '0;
      row_d = '0;
    end else if (step_i) begin
      if (flags_o.x_last) begin
        col_d = '0;
        row_d = flags_o.y_last ? '0 : y + YW'(1);
      end else begin
        col_d = x + XW'(1);
        row_d = y;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

/* sv/region_area_perimeter_accumulator_core.sv */
// ---------------------------------------------------------------------------
// region_area_perimeter_accumulator_core
// Per-label area and 4-neighbour perimeter counts of a labeled raster image.
// ---------------------------------------------------------------------------
// Usage
//   item_i carries one op and one label per transfer: a pixel label in
//   raster order, a read of one label's totals, or a clear that restarts the
//   frame and sweeps the stores to zero (perimeter entries 0 and 1 to 1).
//   result_o returns area and perimeter for reads only, in order.
//   The user writes image width, height and background label on the cfg
//   port only while no item is in flight; the block does not enforce it.
//   Spacing: acc_q holds item_i.ready low after each transfer. Each pixel
//   may update two perimeter entries by read-modify-write, and the perimeter
//   store has one read port, so a pixel may use it in stage 1 and stage 2.
//   A read passes stages 1 and 2, then its result enters the output queue.
//   Reset and clear: a sweep writes every store entry, one per cycle (a
//   clear first lets the work in flight drain); item_i.ready stays low
//   meanwhile, cfg writes are taken as usual.
//   Stall: results wait in a 2-entry output queue; item_i.ready also drops
//   when that queue and the read in flight would fill it.
// ---------------------------------------------------------------------------
module region_area_perimeter_accumulator_core import rapa_pkg::*; #(
  parameter int MAX_LABELS = DEF_MAX_LABELS,
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  rapa_item_if.sink             item_i,
  rapa_result_if.source         result_o
);

  localparam int LW = $clog2(MAX_LABELS);
  localparam int XW = $clog2(MAX_WIDTH);

  function automatic logic [AREA_W-1:0] area_inc(input logic [AREA_W-1:0] a);
    area_inc = (a == AREA_MAX) ? a : a + AREA_W'(1);
  endfunction

  function automatic logic [PERIM_W-1:0] perim_add(input logic [PERIM_W-1:0] p,
                                                   input logic [INC_W-1:0]   n);
    logic [PERIM_W:0] sum;
    sum = (PERIM_W+1)'(p) + (PERIM_W+1)'(n);
    perim_add = (sum > (PERIM_W+1)'(PERIM_MAX)) ? PERIM_MAX : sum[PERIM_W-1:0];
  endfunction

  // configuration registers
  logic [SIZE_W-1:0]  image_width_q;
  logic [SIZE_W-1:0]  image_height_q;
  logic [LABEL_W-1:0] bg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q  <= RST_IMAGE_WIDTH;
      image_height_q <= RST_IMAGE_HEIGHT;
      bg_q           <= RST_BACKGROUND;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IMAGE_WIDTH:  image_width_q  <= cfg_data_i[SIZE_W-1:0];
        CFG_IMAGE_HEIGHT: image_height_q <= cfg_data_i[SIZE_W-1:0];
        CFG_BACKGROUND:   bg_q           <= cfg_data_i[LABEL_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline and control state
  logic               acc_q;
  logic               sweep_q;
  logic [LW-1:0]      sweep_addr_q;
  logic [LABEL_W-1:0] left_q;

  logic               s1_vld_q, s1_rd_q, s1_lab_ok_q, s1_cur_bg_q;
  logic [LW-1:0]      s1_addr_q;
  logic [LABEL_W-1:0] s1_left_q;
  logic               s1_left_cr_q, s1_up_chk_q;
  logic [INC_W-1:0]   s1_base_q;

  logic               s2_vld_q, s2_rd_q, s2_lab_ok_q;
  logic               s2_t0_vld_q, s2_t1_vld_q;
  logic [LW-1:0]      s2_t0_addr_q, s2_t1_addr_q;
  logic [INC_W-1:0]   s2_t0_inc_q;
  logic [AREA_W-1:0]  s2_area_q;

  logic               s3_vld_q;
  logic [LW-1:0]      s3_addr_q;

  // output queue
  logic [1:0]         q_cnt_q;
  logic [AREA_W-1:0]  e0_area_q, e1_area_q;
  logic [PERIM_W-1:0] e0_perim_q, e1_perim_q;

  // input transfer decode
  logic          item_acc, is_pix, is_rd, is_clr, lab_ok, cur_bg, left_bg, left_ok;
  logic [LW-1:0] item_addr;
  logic [XW-1:0] pos_x;
  pos_flags_t    pos_flags;
  logic [INC_W-1:0] base_inc;

  assign item_i.ready = !acc_q && !sweep_q && ((q_cnt_q + {1'b0, s2_rd_q}) < 2'd2);

  always_comb begin
    item_acc  = item_i.valid && item_i.ready;
    is_pix    = item_acc && (item_i.op == OP_PIXEL);
    is_rd     = item_acc && (item_i.op == OP_READ);
    is_clr    = item_acc && (item_i.op == OP_CLEAR);
    lab_ok    = 32'(item_i.label) < 32'(MAX_LABELS);
    item_addr = LW'(item_i.label);
    cur_bg    = (item_i.label == bg_q);
    left_bg   = (left_q == bg_q);
    left_ok   = 32'(left_q) < 32'(MAX_LABELS);
    base_inc  = INC_W'(pos_flags.x_first) + INC_W'(pos_flags.x_last)
              + INC_W'(pos_flags.y_first) + INC_W'(pos_flags.y_last)
              + INC_W'(!pos_flags.x_first && left_bg);
  end

  rapa_raster #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_raster (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (is_pix),
    .restart_i      (is_clr),
    .image_width_i  (image_width_q),
    .image_height_i (image_height_q),
    .x_o            (pos_x),
    .flags_o        (pos_flags)
  );

  // row buffer: upper neighbour read, then overwritten by this pixel
  logic [LABEL_W-1:0] row_buf [MAX_WIDTH];
  logic [LABEL_W-1:0] up_q;

  always_ff @(posedge clk_i) begin
    if (is_pix) begin
      up_q           <= row_buf[pos_x];
      row_buf[pos_x] <= item_i.label;
    end
  end

  // stage 1 capture
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q    <= 1'b0;
      s1_vld_q <= 1'b0;
      s1_rd_q  <= 1'b0;
      left_q   <= '0;
    end else begin
      acc_q    <= item_acc;
      s1_vld_q <= is_pix || is_rd;
      s1_rd_q  <= is_rd;
      if (is_clr) begin
        left_q <= '0;
      end else if (is_pix) begin
        left_q <= item_i.label;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_acc) begin
      s1_lab_ok_q  <= lab_ok;
      s1_addr_q    <= item_addr;
      s1_cur_bg_q  <= cur_bg;
      s1_left_q    <= left_q;
      s1_left_cr_q <= !pos_flags.x_first && !left_bg && left_ok;
      s1_up_chk_q  <= !pos_flags.y_first;
      s1_base_q    <= base_inc;
    end
  end

  // stage 1: choose perimeter targets from the left and upper neighbours
  logic             s1_pix, up_bg, up_cr, same_lab;
  logic             t0_vld, t1_vld;
  logic [LW-1:0]    t0_addr;
  logic [INC_W-1:0] t0_inc;

  always_comb begin
    s1_pix   = s1_vld_q && !s1_rd_q;
    up_bg    = (up_q == bg_q);
    up_cr    = s1_up_chk_q && !up_bg && (32'(up_q) < 32'(MAX_LABELS));
    same_lab = (s1_left_q == up_q);
    if (s1_cur_bg_q) begin
      t0_vld  = s1_left_cr_q || up_cr;
      t0_addr = s1_left_cr_q ? LW'(s1_left_q) : LW'(up_q);
      t0_inc  = (s1_left_cr_q && up_cr && same_lab) ? INC_W'(2) : INC_W'(1);
      t1_vld  = s1_left_cr_q && up_cr && !same_lab;
    end else begin
      t0_vld  = s1_lab_ok_q;
      t0_addr = s1_addr_q;
      t0_inc  = s1_base_q + INC_W'(s1_up_chk_q && up_bg);
      t1_vld  = 1'b0;
    end
    t0_vld = t0_vld && s1_pix;
    t1_vld = t1_vld && s1_pix;
  end

  // area store: read at transfer, increment and write back in stage 1
  logic [AREA_W-1:0] area_mem [MAX_LABELS];
  logic [AREA_W-1:0] area_rd_q;
  logic              sweep_wr, area_we;
  logic [LW-1:0]     area_wa;
  logic [AREA_W-1:0] area_wd;

  assign sweep_wr = sweep_q && !s1_vld_q && !s2_vld_q && !s3_vld_q;

  always_comb begin
    area_we = sweep_wr || (s1_pix && s1_lab_ok_q);
    area_wa = sweep_wr ? sweep_addr_q : s1_addr_q;
    area_wd = sweep_wr ? '0 : area_inc(area_rd_q);
  end

  always_ff @(posedge clk_i) begin
    if (item_acc && lab_ok) begin
      area_rd_q <= area_mem[item_addr];
    end
    if (area_we) begin
      area_mem[area_wa] <= area_wd;
    end
  end

  // stage 2 capture
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q    <= 1'b0;
      s2_rd_q     <= 1'b0;
      s2_t0_vld_q <= 1'b0;
      s2_t1_vld_q <= 1'b0;
      s3_vld_q    <= 1'b0;
    end else begin
      s2_vld_q    <= s1_vld_q;
      s2_rd_q     <= s1_vld_q && s1_rd_q;
      s2_t0_vld_q <= t0_vld;
      s2_t1_vld_q <= t1_vld;
      s3_vld_q    <= s2_vld_q && s2_t1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_lab_ok_q  <= s1_lab_ok_q;
    s2_t0_addr_q <= t0_addr;
    s2_t0_inc_q  <= t0_inc;
    s2_t1_addr_q <= LW'(up_q);
    s2_area_q    <= s1_lab_ok_q ? area_rd_q : '0;
    s3_addr_q    <= s2_t1_addr_q;
  end

  // perimeter store: one read and one write port, same-cycle forwarding
  logic [PERIM_W-1:0] perim_mem [MAX_LABELS];
  logic [PERIM_W-1:0] perim_rd_q, fw_data_q, p_cur;
  logic               fw_hit_q;
  logic               pr_en, pw_en;
  logic [LW-1:0]      pr_addr, pw_addr;
  logic [PERIM_W-1:0] pw_data;

  always_comb begin
    p_cur   = fw_hit_q ? fw_data_q : perim_rd_q;
    pr_en   = (s1_vld_q && (s1_rd_q ? s1_lab_ok_q : t0_vld))
            || (s2_vld_q && s2_t1_vld_q);
    pr_addr = s1_vld_q ? (s1_rd_q ? s1_addr_q : t0_addr) : s2_t1_addr_q;
    pw_en   = 1'b1;
    pw_addr = s3_addr_q;
    pw_data = perim_add(p_cur, INC_W'(1));
    if (sweep_wr) begin
      pw_addr = sweep_addr_q;
      pw_data = (32'(sweep_addr_q) < 32'd2) ? PERIM_W'(1) : '0;
    end else if (s2_vld_q && s2_t0_vld_q) begin
      pw_addr = s2_t0_addr_q;
      pw_data = perim_add(p_cur, s2_t0_inc_q);
    end else if (!s3_vld_q) begin
      pw_en = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pr_en) begin
      perim_rd_q <= perim_mem[pr_addr];
    end
    if (pw_en) begin
      perim_mem[pw_addr] <= pw_data;
    end
    fw_data_q <= pw_data;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_hit_q <= 1'b0;
    end else begin
      fw_hit_q <= pw_en && (pw_addr == pr_addr);
    end
  end

  // clearing sweep after reset and after a clear
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q      <= 1'b1;
      sweep_addr_q <= '0;
    end else if (is_clr) begin
      sweep_q      <= 1'b1;
      sweep_addr_q <= '0;
    end else if (sweep_wr) begin
      if (sweep_addr_q == LW'(MAX_LABELS - 1)) begin
        sweep_q      <= 1'b0;
        sweep_addr_q <= '0;
      end else begin
        sweep_addr_q <= sweep_addr_q + LW'(1);
      end
    end
  end

  // output queue, head entry drives the result channel
  logic               q_push, q_pop;
  logic [PERIM_W-1:0] push_perim;

  assign q_push     = s2_rd_q;
  assign q_pop      = result_o.valid && result_o.ready;
  assign push_perim = s2_lab_ok_q ? p_cur : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_cnt_q <= '0;
    end else if (q_push && !q_pop) begin
      q_cnt_q <= q_cnt_q + 2'd1;
    end else if (q_pop && !q_push) begin
      q_cnt_q <= q_cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_push && (q_cnt_q == 2'd0 || (q_pop && q_cnt_q == 2'd1))) begin
      e0_area_q  <= s2_area_q;
      e0_perim_q <= push_perim;
    end else if (q_pop) begin
      e0_area_q  <= e1_area_q;
      e0_perim_q <= e1_perim_q;
    end
    if (q_push && ((q_cnt_q == 2'd1 && !q_pop) || (q_cnt_q == 2'd2 && q_pop))) begin
      e1_area_q  <= s2_area_q;
      e1_perim_q <= push_perim;
    end
  end

  assign result_o.valid     = (q_cnt_q != 2'd0);
  assign result_o.area      = e0_area_q;
  assign result_o.perimeter = e0_perim_q;

`ifndef ASSERT_OFF
  // items are spaced so that the store ports are never shared
  a_stage_spacing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s1_vld_q && s2_vld_q) && !(s2_vld_q && s3_vld_q))
    else $error("overlapping pipeline stages");

  // credit check keeps the output queue from overflowing
  a_queue_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> (q_cnt_q != 2'd2 || q_pop))
    else $error("result queue overflow");

  // a clear always starts a sweep and blocks further items
  a_clear_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_clr |=> sweep_q && !item_i.ready)
    else $error("clear did not start sweep");
`endif

endmodule

/* verif/tb_region_area_perimeter_accumulator_core.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_region_area_perimeter_accumulator_core
// Self-checking bench for the area and perimeter accumulator. A directed
// table, then random frames of labeled pixels mixed with reads, clears and
// unused ops, go through the item channel with random gaps on both sides.
// Each read result is compared with the table's totals or with per-label
// totals that the bench keeps itself, pixel by pixel, at the block's widths.
// ---------------------------------------------------------------------------
module tb_region_area_perimeter_accumulator_core;
  import rapa_pkg::*;

  localparam int HALF_PERIOD  = 4;
  localparam int RESET_CYCLES = 10;
  localparam int STALL_LIMIT  = 20000;
  localparam int RANDOM_ITEMS = 1050;
  localparam int DRAIN_CYCLES = 8;
  localparam int END_CYCLES   = 10;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [AREA_W-1:0]  area;
    logic [PERIM_W-1:0] perimeter;
  } totals_t;

  // one row of the directed table: a register write or an item
  typedef struct {
    bit                    is_reg;
    cfg_idx_e              reg_idx;
    logic [OP_W-1:0]       op;
    logic [CFG_DATA_W-1:0] value;
    bit                    typed;
    totals_t               want;
  } step_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  rapa_item_if   item_bus ();
  rapa_result_if result_bus ();

  region_area_perimeter_accumulator_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .item_i     (item_bus),
    .result_o   (result_bus)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  // bench copy of the label stores, position and registers
  logic [AREA_W-1:0]  label_area  [DEF_MAX_LABELS];
  logic [PERIM_W-1:0] label_perim [DEF_MAX_LABELS];
  logic [LABEL_W-1:0] upper_row   [DEF_MAX_WIDTH];
  logic [LABEL_W-1:0] west_label;
  int unsigned        next_col;
  int unsigned        next_row;
  int unsigned        row_fill;
  logic [SIZE_W-1:0]  width_reg;
  logic [SIZE_W-1:0]  height_reg;
  logic [LABEL_W-1:0] bg_reg;

  totals_t     pending_totals[$];
  int unsigned mismatches = 0;
  bit          gaps_on    = 1'b1;

  function automatic int unsigned used_dim(logic [SIZE_W-1:0] v, int unsigned top);
    if (v < 2) return 2;
    if (v > top) return top;
    return v;
  endfunction

  function automatic void wipe_counts();
    for (int i = 0; i < DEF_MAX_LABELS; i++) begin
      label_area[i]  = '0;
      label_perim[i] = '0;
    end
    label_perim[0] = PERIM_W'(1);
    label_perim[1] = PERIM_W'(1);
    west_label     = '0;
    next_col       = 0;
    next_row       = 0;
  endfunction

  function automatic void add_sides(logic [LABEL_W-1:0] lab, int unsigned n);
    int unsigned sum;
    if (n == 0) return;
    sum = label_perim[lab] + n;
    label_perim[lab] = (sum > PERIM_MAX) ? PERIM_MAX : PERIM_W'(sum);
  endfunction

  function automatic void account_pixel(logic [LABEL_W-1:0] lab);
    int unsigned        w, h, x, y, n;
    logic [LABEL_W-1:0] up;
    bit                 fg;
    w  = used_dim(width_reg, DEF_MAX_WIDTH);
    h  = used_dim(height_reg, DEF_MAX_HEIGHT);
    fg = (lab != bg_reg);
    n  = 0;
    // size lowered since the last pixel: next row or new frame
    if (next_col >= w) begin
      next_col = 0;
      next_row++;
    end
    if (next_row >= h) next_row = 0;
    x = next_col;
    y = next_row;
    if (label_area[lab] != AREA_MAX) label_area[lab]++;
    // sides on the image border
    if (fg) n = int'(x == 0) + int'(x == w - 1) + int'(y == 0) + int'(y == h - 1);
    // west side goes to whichever of the pair is foreground
    if (x > 0) begin
      if (fg && west_label == bg_reg) n++;
      if (!fg && west_label != bg_reg) add_sides(west_label, 1);
    end
    // north side from the previous row
    if (y > 0) begin
      up = upper_row[x];
      if (fg && up == bg_reg) n++;
      if (!fg && up != bg_reg) add_sides(up, 1);
    end
    add_sides(lab, n);
    upper_row[x] = lab;
    if (x >= row_fill) row_fill = x + 1;
    west_label = lab;
    next_col   = x + 1;
    if (next_col >= w) begin
      next_col = 0;
      next_row = y + 1;
      if (next_row >= h) next_row = 0;
    end
  endfunction

  function automatic totals_t label_totals(logic [LABEL_W-1:0] lab);
    totals_t t;
    t.area      = label_area[lab];
    t.perimeter = label_perim[lab];
    return t;
  endfunction

  // directed table rows
  function automatic step_t item_step(logic [OP_W-1:0] op, logic [LABEL_W-1:0] lab);
    step_t s;
    s        = '{default: '0, reg_idx: CFG_IMAGE_WIDTH};
    s.op     = op;
    s.value  = lab;
    return s;
  endfunction

  function automatic step_t read_step(logic [LABEL_W-1:0] lab, int unsigned a,
                                      int unsigned p);
    step_t s;
    s                = item_step(OP_READ, lab);
    s.typed          = 1'b1;
    s.want.area      = AREA_W'(a);
    s.want.perimeter = PERIM_W'(p);
    return s;
  endfunction

  function automatic step_t reg_step(cfg_idx_e idx, logic [CFG_DATA_W-1:0] v);
    step_t s;
    s         = '{default: '0, reg_idx: CFG_IMAGE_WIDTH};
    s.is_reg  = 1'b1;
    s.reg_idx = idx;
    s.value   = v;
    return s;
  endfunction

  // random picks
  function automatic logic [CFG_DATA_W-1:0] pick_dim();
    case ($urandom_range(0, 9))
      0:       return CFG_DATA_W'(0);
      1:       return CFG_DATA_W'(1);
      2:       return CFG_DATA_W'(1024);
      3:       return CFG_DATA_W'(2047);
      4:       return CFG_DATA_W'($urandom_range(9, 2047));
      default: return CFG_DATA_W'($urandom_range(2, 8));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_bg();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return CFG_DATA_W'($urandom);
      default: return CFG_DATA_W'($urandom_range(0, 3));
    endcase
  endfunction

  function automatic logic [LABEL_W-1:0] pick_pixel(logic [LABEL_W-1:0] last);
    if ($urandom_range(0, 1) != 0) return last;
    case ($urandom_range(0, 9))
      0:       return '1;
      1:       return LABEL_W'($urandom);
      2, 3, 4: return bg_reg;
      default: return LABEL_W'($urandom_range(0, 3));
    endcase
  endfunction

  function automatic logic [LABEL_W-1:0] pick_read(logic [LABEL_W-1:0] last);
    case ($urandom_range(0, 9))
      0, 1:    return bg_reg;
      2:       return last;
      3:       return LABEL_W'($urandom);
      4:       return '1;
      default: return LABEL_W'($urandom_range(0, 3));
    endcase
  endfunction

  // drive one item and update the bench state on its transfer
  task automatic send_item(input logic [OP_W-1:0] op, input logic [LABEL_W-1:0] lab,
                           input bit typed = 1'b0, input totals_t want = '0);
    int unsigned gap;
    gap = gaps_on ? $urandom_range(0, 4) : 0;
    @(negedge clk_i);
    if (gap != 0) begin
      item_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    item_bus.valid <= 1'b1;
    item_bus.op    <= op;
    item_bus.label <= lab;
    do @(posedge clk_i); while (!(item_bus.valid && item_bus.ready));
    case (op)
      OP_PIXEL: account_pixel(lab);
      OP_READ:  pending_totals.push_back(typed ? want : label_totals(lab));
      OP_CLEAR: wipe_counts();
      default:  ;
    endcase
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] v);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_IMAGE_WIDTH:  width_reg  = v[SIZE_W-1:0];
      CFG_IMAGE_HEIGHT: height_reg = v[SIZE_W-1:0];
      CFG_BACKGROUND:   bg_reg     = v[LABEL_W-1:0];
      default:          ;
    endcase
  endtask

  // stop items, let reads return and any pixel or clear sweep finish
  task automatic settle_block();
    @(negedge clk_i);
    item_bus.valid <= 1'b0;
    while (pending_totals.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    while (!item_bus.ready) @(posedge clk_i);
  endtask

  // result side: random ready gaps per transfer
  initial begin : result_drain
    int unsigned hold;
    result_bus.ready = 1'b0;
    forever begin
      hold = gaps_on ? $urandom_range(0, 4) : 0;
      @(negedge clk_i);
      if (hold != 0) begin
        result_bus.ready <= 1'b0;
        repeat (hold) @(negedge clk_i);
      end
      result_bus.ready <= 1'b1;
      do @(posedge clk_i); while (!(result_bus.valid && result_bus.ready));
    end
  end

  // compare each result transfer with the oldest pending read
  always @(posedge clk_i) begin : totals_check
    totals_t want;
    if (result_bus.valid && result_bus.ready) begin
      if (pending_totals.size() == 0) begin
        $error("read result with no read pending: area %0d perimeter %0d",
               result_bus.area, result_bus.perimeter);
        mismatches++;
      end else begin
        want = pending_totals.pop_front();
        if (result_bus.area !== want.area) begin
          $error("area: expected %0d, got %0d", want.area, result_bus.area);
          mismatches++;
        end
        if (result_bus.perimeter !== want.perimeter) begin
          $error("perimeter: expected %0d, got %0d", want.perimeter, result_bus.perimeter);
          mismatches++;
        end
      end
    end
  end

  // end the run when no transfer happens for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    step_t              plan[$];
    int unsigned        random_items;
    int unsigned        phase_len;
    int unsigned        roll;
    logic [LABEL_W-1:0] last_pix;
    bit                 prev_reg;

    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = '0;
    cfg_data_i     = '0;
    item_bus.valid = 1'b0;
    item_bus.op    = '0;
    item_bus.label = '0;

    wipe_counts();
    for (int i = 0; i < DEF_MAX_WIDTH; i++) upper_row[i] = '0;
    row_fill   = 0;
    width_reg  = RST_IMAGE_WIDTH;
    height_reg = RST_IMAGE_HEIGHT;
    bg_reg     = RST_BACKGROUND;
    last_pix   = '0;

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // presets after reset, then a foreground pixel at the top-left corner
    plan.push_back(read_step(12'd0, 0, 1));
    plan.push_back(read_step(12'd1, 0, 1));
    plan.push_back(read_step(12'hFFF, 0, 0));
    plan.push_back(item_step(OP_PIXEL, 12'hFFF));
    plan.push_back(read_step(12'hFFF, 1, 2));
    // background to its right credits the shared side to the left pixel
    plan.push_back(item_step(OP_PIXEL, 12'd0));
    plan.push_back(read_step(12'hFFF, 1, 3));
    // unused op does nothing, clear brings the presets back
    plan.push_back(item_step(OP_UNUSED, 12'hFFF));
    plan.push_back(item_step(OP_CLEAR, 12'hA5A));
    plan.push_back(read_step(12'hFFF, 0, 0));
    plan.push_back(read_step(12'd0, 0, 1));
    // smallest frame with the highest background label
    plan.push_back(reg_step(CFG_IMAGE_WIDTH, 12'd2));
    plan.push_back(reg_step(CFG_IMAGE_HEIGHT, 12'd2));
    plan.push_back(reg_step(CFG_BACKGROUND, 12'hFFF));
    plan.push_back(item_step(OP_PIXEL, 12'd7));
    plan.push_back(item_step(OP_PIXEL, 12'hFFF));
    plan.push_back(item_step(OP_PIXEL, 12'hFFF));
    plan.push_back(item_step(OP_PIXEL, 12'd0));
    plan.push_back(item_step(OP_READ, 12'd7));
    plan.push_back(item_step(OP_READ, 12'd0));
    // end of frame wraps to the first pixel
    plan.push_back(item_step(OP_PIXEL, 12'd7));
    // wider frame while still in row zero
    plan.push_back(reg_step(CFG_IMAGE_WIDTH, 12'd4));
    plan.push_back(reg_step(CFG_IMAGE_HEIGHT, 12'd4));
    plan.push_back(item_step(OP_PIXEL, 12'd3));
    plan.push_back(item_step(OP_PIXEL, 12'd3));
    plan.push_back(item_step(OP_PIXEL, 12'd3));
    plan.push_back(item_step(OP_PIXEL, 12'd3));
    plan.push_back(item_step(OP_PIXEL, 12'hFFF));
    // sizes below the minimum, position now past both width and height
    plan.push_back(reg_step(CFG_IMAGE_WIDTH, 12'd1));
    plan.push_back(reg_step(CFG_IMAGE_HEIGHT, 12'd1));
    plan.push_back(reg_step(CFG_BACKGROUND, 12'd0));
    plan.push_back(item_step(OP_PIXEL, 12'd3));
    plan.push_back(item_step(OP_READ, 12'd3));
    // sizes above the maximum, raised in row zero
    plan.push_back(reg_step(CFG_IMAGE_WIDTH, 12'd2047));
    plan.push_back(reg_step(CFG_IMAGE_HEIGHT, 12'd2047));
    plan.push_back(item_step(OP_PIXEL, 12'd5));
    plan.push_back(item_step(OP_READ, 12'd5));
    plan.push_back(item_step(OP_READ, 12'hFFF));

    prev_reg = 1'b0;
    foreach (plan[i]) begin
      if (plan[i].is_reg) begin
        if (!prev_reg) settle_block();
        write_reg(plan[i].reg_idx, plan[i].value);
      end else begin
        send_item(plan[i].op, plan[i].value[LABEL_W-1:0], plan[i].typed, plan[i].want);
      end
      prev_reg = plan[i].is_reg;
    end

    // random phases, each with fresh sizes and background
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      settle_block();
      write_reg(CFG_IMAGE_WIDTH, pick_dim());
      write_reg(CFG_IMAGE_HEIGHT, pick_dim());
      write_reg(CFG_BACKGROUND, pick_bg());
      gaps_on = ($urandom_range(0, 3) != 0);
      // a wider row past row zero would read row buffer entries never written
      if (next_row != 0 && used_dim(width_reg, DEF_MAX_WIDTH) > row_fill) begin
        send_item(OP_CLEAR, LABEL_W'($urandom));
        random_items++;
      end
      phase_len = $urandom_range(20, 60);
      for (int k = 0; k < phase_len; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < 78) begin
          last_pix = pick_pixel(last_pix);
          send_item(OP_PIXEL, last_pix);
          random_items++;
        end else if (roll < 94) begin
          send_item(OP_READ, pick_read(last_pix));
          random_items++;
        end else if (roll < 97) begin
          send_item(OP_UNUSED, LABEL_W'($urandom));
        end else begin
          send_item(OP_CLEAR, LABEL_W'($urandom));
          random_items++;
        end
      end
    end

    // wait out the last reads
    @(negedge clk_i);
    item_bus.valid <= 1'b0;
    while (pending_totals.size() != 0) @(posedge clk_i);
    repeat (END_CYCLES) @(posedge clk_i);
    if (mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
